// ----- design/reed_solomon_encoder_core_defines.svh -----
// Assertion macros used by the checker of the Reed-Solomon encoder.
// No dependencies; the checker takes this header by include.
`ifndef REED_SOLOMON_ENCODER_CORE_DEFINES_SVH
`define REED_SOLOMON_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rse same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rse next-cycle check failed");

`endif

// ----- design/rse_pkg.sv -----
// Types, register indexes, state encoding and GF(256) arithmetic for the
// Reed-Solomon encoder. No dependencies.
package rse_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_npar;
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DATA_LENGTH  = 2'd0;
    localparam t_cfg_idx REG_PARITY_COUNT = 2'd1;

    localparam t_byte DATA_LENGTH_RST  = 8'd223;
    localparam t_npar PARITY_COUNT_RST = 6'd32;

    // Low byte of the field polynomial 0x11d.
    localparam t_byte GF_POLY_LOW = 8'h1d;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_BUILD,
        ST_RUN
    } t_state;

    function automatic t_byte gf_xtime(t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    function automatic t_byte gf_mul(t_byte x, t_byte y);
        t_byte a;
        t_byte acc;
        a   = x;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc = acc ^ a;
            end
            a = gf_xtime(a);
        end
        return acc;
    endfunction

endpackage

// ----- design/rse_if.sv -----
// Stream interfaces of the Reed-Solomon encoder: data bytes in, code bytes out.
// Depends on rse_pkg.
interface rse_data_if;
    logic          valid;
    logic          ready;
    rse_pkg::t_byte data_byte;

    modport source(output valid, output data_byte, input ready);
    modport sink(input valid, input data_byte, output ready);
endinterface

interface rse_code_if;
    logic          valid;
    logic          ready;
    rse_pkg::t_byte code_byte;
    logic          is_parity;
    logic          last;

    modport source(output valid, output code_byte, output is_parity, output last,
                   input ready);
    modport sink(input valid, input code_byte, input is_parity, input last,
                 output ready);
endinterface

// ----- design/reed_solomon_encoder_core.sv -----
// Systematic Reed-Solomon encoder over GF(256), top level.
// Depends on rse_pkg and the interfaces in rse_if.sv.
//
//   Channel   Direction  Payload                        Transaction
//   i_data    in         data_byte                      valid & ready
//   o_code    out        code_byte, is_parity, last     valid & ready
//   i_cfg_*   in         index, data                    i_cfg_we high
//
// A data byte is taken every cycle while i_data.ready is high; the parity
// register updates in one pass. After a codeword's final data byte, npar parity
// bytes leave the parity register one per cycle unless the output stalls.
// i_data.ready is low then and while ST_INIT and ST_BUILD rebuild the generator
// after reset and each parity_count write. A single output register decouples
// the sides; a stalled output holds its transaction and stalls the input.
module reed_solomon_encoder_core #(
    parameter int unsigned MAX_PARITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  rse_pkg::t_cfg_idx i_cfg_idx,
    input  rse_pkg::t_byte    i_cfg_data,
    rse_data_if.sink          i_data,
    rse_code_if.source        o_code
);

    rse_pkg::t_byte  r_data_length;
    rse_pkg::t_npar  r_parity_count;
    rse_pkg::t_state r_state;
    rse_pkg::t_state n_state;

    rse_pkg::t_byte  r_cells  [MAX_PARITY];
    rse_pkg::t_byte  r_coeffs [MAX_PARITY];
    rse_pkg::t_byte  r_root;
    rse_pkg::t_npar  r_gen_cnt;
    rse_pkg::t_byte  r_byte_index;
    rse_pkg::t_npar  r_emit_cnt;

    logic            r_out_valid;
    rse_pkg::t_byte  r_out_code;
    logic            r_out_is_parity;
    logic            r_out_last;

    rse_pkg::t_byte  w_above      [MAX_PARITY];
    rse_pkg::t_byte  w_coef_above [MAX_PARITY];
    rse_pkg::t_byte  w_cell_upd   [MAX_PARITY];
    rse_pkg::t_byte  w_coef_upd   [MAX_PARITY];
    rse_pkg::t_byte  w_coef_init  [MAX_PARITY];

    rse_pkg::t_npar  w_npar;
    logic [8:0]      w_k_top;
    logic [8:0]      w_k;
    logic            w_final;
    rse_pkg::t_byte  w_fb;
    logic            w_pc_write;
    logic            w_out_free;
    logic            w_in_ready;
    logic            w_accept;
    logic            w_emit_load;
    logic            s_init;
    logic            s_build;
    logic            s_run;

    // Effective parity count and data length.
    always_comb begin
        if (r_parity_count == '0) begin
            w_npar = 6'd1;
        end else if ({2'b00, r_parity_count} > 8'(MAX_PARITY)) begin
            w_npar = 6'(MAX_PARITY);
        end else begin
            w_npar = r_parity_count;
        end
    end

    always_comb begin
        w_k_top = 9'd255 - {3'b000, w_npar};
        if (r_data_length == '0) begin
            w_k = 9'd1;
        end else if ({1'b0, r_data_length} > w_k_top) begin
            w_k = w_k_top;
        end else begin
            w_k = {1'b0, r_data_length};
        end
    end

    assign w_final     = ({1'b0, r_byte_index} + 9'd1) >= w_k;
    assign w_fb        = r_cells[0] ^ i_data.data_byte;
    assign w_pc_write  = i_cfg_we && (i_cfg_idx == rse_pkg::REG_PARITY_COUNT);
    assign w_out_free  = !r_out_valid || o_code.ready;
    assign w_in_ready  = s_run && (r_emit_cnt == '0) && w_out_free;
    assign w_accept    = i_data.valid && w_in_ready;
    assign w_emit_load = (r_emit_cnt != '0) && w_out_free;

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_lane
        if (j + 1 < MAX_PARITY) begin : g_mid
            assign w_above[j]      = r_cells[j + 1];
            assign w_coef_above[j] = r_coeffs[j + 1];
        end else begin : g_top
            assign w_above[j]      = '0;
            assign w_coef_above[j] = '0;
        end
        assign w_cell_upd[j]  = w_above[j] ^ rse_pkg::gf_mul(w_fb, r_coeffs[j]);
        assign w_coef_upd[j]  = rse_pkg::gf_mul(r_coeffs[j], r_root) ^ w_coef_above[j];
        assign w_coef_init[j] = (8'(j + 1) == {2'b00, w_npar}) ? 8'd1 : 8'd0;
    end

    // Generator build sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::ST_INIT: begin
                n_state = rse_pkg::ST_BUILD;
            end
            rse_pkg::ST_BUILD: begin
                if (r_gen_cnt == (w_npar - 6'd1)) begin
                    n_state = rse_pkg::ST_RUN;
                end
            end
            rse_pkg::ST_RUN: begin
                n_state = rse_pkg::ST_RUN;
            end
            default: begin
                n_state = rse_pkg::ST_INIT;
            end
        endcase
        if (w_pc_write) begin
            n_state = rse_pkg::ST_INIT;
        end
    end

    always_comb begin
        s_init  = 1'b0;
        s_build = 1'b0;
        s_run   = 1'b0;
        case (r_state)
            rse_pkg::ST_INIT:  s_init  = 1'b1;
            rse_pkg::ST_BUILD: s_build = 1'b1;
            rse_pkg::ST_RUN:   s_run   = 1'b1;
            default:           s_init  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= rse_pkg::ST_INIT;
            r_data_length  <= rse_pkg::DATA_LENGTH_RST;
            r_parity_count <= rse_pkg::PARITY_COUNT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == rse_pkg::REG_DATA_LENGTH)) begin
                r_data_length <= i_cfg_data;
            end
            if (w_pc_write) begin
                r_parity_count <= i_cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_init) begin
            r_root    <= 8'd1;
            r_gen_cnt <= '0;
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_coeffs[j] <= w_coef_init[j];
            end
        end else if (s_build) begin
            r_root    <= rse_pkg::gf_xtime(r_root);
            r_gen_cnt <= r_gen_cnt + 6'd1;
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_coeffs[j] <= w_coef_upd[j];
            end
        end
    end

    // Parity register: updated per data byte, shifted out during parity emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_pc_write) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_cells[j] <= '0;
            end
        end else if (w_accept) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_cells[j] <= w_cell_upd[j];
            end
        end else if (w_emit_load) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_cells[j] <= w_above[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_pc_write) begin
            r_byte_index <= '0;
            r_emit_cnt   <= '0;
        end else if (w_accept) begin
            if (w_final) begin
                r_byte_index <= '0;
                r_emit_cnt   <= w_npar;
            end else begin
                r_byte_index <= r_byte_index + 8'd1;
            end
        end else if (w_emit_load) begin
            r_emit_cnt <= r_emit_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept || w_emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_code      <= i_data.data_byte;
            r_out_is_parity <= 1'b0;
            r_out_last      <= 1'b0;
        end else if (w_emit_load) begin
            r_out_code      <= r_cells[0];
            r_out_is_parity <= 1'b1;
            r_out_last      <= (r_emit_cnt == 6'd1);
        end
    end

    assign i_data.ready     = w_in_ready;
    assign o_code.valid     = r_out_valid;
    assign o_code.code_byte = r_out_code;
    assign o_code.is_parity = r_out_is_parity;
    assign o_code.last      = r_out_last;

endmodule

// ----- design/rse_checker.sv -----
// Port-level checker for the Reed-Solomon encoder, bound to its top level.
// Depends on rse_pkg and reed_solomon_encoder_core_defines.svh.
`include "reed_solomon_encoder_core_defines.svh"

module rse_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input rse_pkg::t_cfg_idx i_cfg_idx,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input rse_pkg::t_byte    i_in_data,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input rse_pkg::t_byte    i_out_code,
    input logic              i_out_is_parity,
    input logic              i_out_last
);

    `RSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_code) && $stable(i_out_last))

    `RSE_ASSERT_NEXT(a_data_passes, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid && !i_out_is_parity && !i_out_last && (i_out_code == $past(i_in_data)))

    `RSE_ASSERT_IMP(a_no_input_mid_parity, i_clk, i_rst_n, i_out_valid && i_out_is_parity && !i_out_last, !i_in_ready)

    `RSE_ASSERT_NEXT(a_parity_runs_on, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_is_parity && !i_out_last, i_out_valid && i_out_is_parity)

    `RSE_ASSERT_NEXT(a_rebuild_stalls, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == rse_pkg::REG_PARITY_COUNT), !i_in_ready)

endmodule

bind reed_solomon_encoder_core rse_checker u_rse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_idx       (i_cfg_idx),
    .i_in_valid      (i_data.valid),
    .i_in_ready      (i_data.ready),
    .i_in_data       (i_data.data_byte),
    .i_out_valid     (o_code.valid),
    .i_out_ready     (o_code.ready),
    .i_out_code      (o_code.code_byte),
    .i_out_is_parity (o_code.is_parity),
    .i_out_last      (o_code.last)
);
